// ===== src/smo_pkg.sv =====
package smo_pkg;

  localparam int WORD_W = 32;

  localparam logic [1:0] CMD_PUSH     = 2'd0;
  localparam logic [1:0] CMD_POP      = 2'd1;
  localparam logic [1:0] CMD_READ_MID = 2'd2;
  localparam logic [1:0] CMD_DEL_MID  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [1:0]               status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RDWAIT,
    S_SHIFT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic decode;
    logic cap_word;
    logic shift_start;
    logic shift_step;
    logic dec_count;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       empty;
    logic       start_more;
    logic       step_more;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== src/smo_ram.sv =====
module smo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/smo_ctrl.sv =====
module smo_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  smo_pkg::dp_status_t   sts,
  output smo_pkg::ctrl_cmd_t    cmd
);

  smo_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smo_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smo_pkg::S_IDLE: begin
        if (in_valid) state_nxt = smo_pkg::S_DECODE;
      end
      smo_pkg::S_DECODE: begin
        if (sts.command == smo_pkg::CMD_PUSH || sts.empty) state_nxt = smo_pkg::S_EMIT;
        else state_nxt = smo_pkg::S_RDWAIT;
      end
      smo_pkg::S_RDWAIT: begin
        if (sts.command == smo_pkg::CMD_DEL_MID && sts.start_more) state_nxt = smo_pkg::S_SHIFT;
        else state_nxt = smo_pkg::S_EMIT;
      end
      smo_pkg::S_SHIFT: begin
        if (!sts.step_more) state_nxt = smo_pkg::S_EMIT;
      end
      smo_pkg::S_EMIT: begin
        if (sts.out_free) state_nxt = smo_pkg::S_IDLE;
      end
      default: state_nxt = smo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      smo_pkg::S_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_in = in_valid;
      end
      smo_pkg::S_DECODE: begin
        cmd.decode = 1'b1;
      end
      smo_pkg::S_RDWAIT: begin
        cmd.cap_word = 1'b1;
        if (sts.command == smo_pkg::CMD_DEL_MID) begin
          cmd.shift_start = sts.start_more;
          cmd.dec_count   = !sts.start_more;
        end
      end
      smo_pkg::S_SHIFT: begin
        cmd.shift_step = 1'b1;
        cmd.dec_count  = !sts.step_more;
      end
      smo_pkg::S_EMIT: begin
        cmd.load_out = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/smo_dp.sv =====
module smo_dp #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smo_pkg::in_item_t     in_item,
  input  logic                  out_stall,
  output logic                  out_valid,
  output smo_pkg::out_item_t    out_item,
  input  smo_pkg::ctrl_cmd_t    cmd,
  output smo_pkg::dp_status_t   sts
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [1:0]                        cmd_r;
  logic signed [smo_pkg::WORD_W-1:0] val_r;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [AW-1:0]                     idx_r, idx_nxt;
  logic signed [smo_pkg::WORD_W-1:0] res_value_r, res_value_nxt;
  logic [1:0]                        res_status_r, res_status_nxt;
  logic                              out_valid_r;
  smo_pkg::out_item_t                out_item_r;

  logic                       empty, full;
  logic [AW-1:0]              mid;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [smo_pkg::WORD_W-1:0] wr_data, rd_data;

  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(STACK_DEPTH));
  assign mid   = AW'(count_r >> 1);

  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data;
    rd_addr        = AW'(idx_r + AW'(2));
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    if (cmd.decode) begin
      if (cmd_r == smo_pkg::CMD_PUSH) begin
        res_value_nxt = '0;
        if (full) begin
          res_status_nxt = smo_pkg::STAT_FULL;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = AW'(count_r);
          wr_data        = val_r;
          count_nxt      = count_r + CW'(1);
          res_status_nxt = smo_pkg::STAT_OK;
        end
      end else if (empty) begin
        res_value_nxt  = smo_pkg::EMPTY_WORD;
        res_status_nxt = smo_pkg::STAT_EMPTY;
      end else if (cmd_r == smo_pkg::CMD_POP) begin
        rd_addr   = AW'(count_r - CW'(1));
        count_nxt = count_r - CW'(1);
      end else begin
        rd_addr = mid;
      end
    end
    if (cmd.cap_word) begin
      res_value_nxt  = rd_data;
      res_status_nxt = smo_pkg::STAT_OK;
    end
    if (cmd.shift_start) begin
      idx_nxt = mid;
      rd_addr = AW'(mid + AW'(1));
    end
    if (cmd.shift_step) begin
      wr_en   = 1'b1;
      idx_nxt = idx_r + AW'(1);
    end
    if (cmd.dec_count) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r <= in_item.command;
      val_r <= in_item.push_value;
    end
    idx_r        <= idx_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.load_out) begin
      out_item_r.read_value <= res_value_r;
      out_item_r.status     <= res_status_r;
    end
  end

  smo_ram #(
    .WIDTH(smo_pkg::WORD_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign sts.command    = cmd_r;
  assign sts.empty      = empty;
  assign sts.start_more = ((CW + 1)'(mid) + (CW + 1)'(1)) < (CW + 1)'(count_r);
  assign sts.step_more  = ((CW + 1)'(idx_r) + (CW + 1)'(2)) < (CW + 1)'(count_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== src/stack_with_middle_ops.sv =====
// Channel | Direction | Handshake          | Transaction payload
// in_     | input     | in_valid/in_stall   | in_item: command, push_value
// out_    | output    | out_valid/out_stall | out_item: read_value, status
//
// One request is worked at a time. Push and all empty or full answers go
// from decode straight to result load; pop and read middle first wait on
// the word read. Delete middle then moves n - 1 - n/2 words for n stored
// words, one word moved per cycle through the single-write, registered-read
// word memory.
// Reset (rst_n low, synchronous) empties the stack; memory contents are kept.
// A new request is taken while the previous result still waits under
// out_stall; its result is held back until the output register is free.
module stack_with_middle_ops #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  smo_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output smo_pkg::out_item_t  out_item
);

  // Commands from the controller, flags back from the datapath.
  smo_pkg::ctrl_cmd_t  cmd;
  smo_pkg::dp_status_t sts;

  // Sequence each transaction: decode, memory read, shift, result load.
  smo_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Hold the word memory, item count, shift index and output register.
  smo_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_item (out_item),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Stall new requests for the cycle after acceptance: only one in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another was in progress");

  // A result never appears while its request is still in the decode state.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // An empty answer always carries the all-ones word.
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == smo_pkg::STAT_EMPTY) |->
      (out_item.read_value == smo_pkg::EMPTY_WORD))
    else $error("empty status without all-ones word");

  // Shifting only happens once the datapath reports more words above.
  a_shift_guard: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_start |-> (sts.start_more && !sts.empty))
    else $error("shift started with nothing to move");

endmodule

// ===== verif/stack_with_middle_ops_test.sv =====
`timescale 1ns / 1ps

module stack_with_middle_ops_test;

  localparam int          STACK_DEPTH     = 256;
  localparam int          RESET_CYCLES    = 9;
  localparam int          RANDOM_ITEMS    = 1125;
  // Worst case is a delete at full depth plus the random gaps on both
  // sides; allow several times that for every item.
  localparam int          CYCLE_LIMIT     = 1_000_000;
  localparam int          HOLD_OFF_CYCLES = 400;
  // Longest single request is a delete at full depth.
  localparam int          DRAIN_CYCLES    = 300;

  // One row of the directed table: the request, and where the answer is
  // obvious at a glance, the answer typed in by hand.
  typedef struct {
    smo_pkg::in_item_t  req;
    bit                 fixed;
    smo_pkg::out_item_t want;
  } directed_row_t;

  // Steering of the random part: grow towards full, shrink towards empty,
  // or wander about the current depth.
  typedef enum {GROW, SHRINK, WANDER} depth_trend_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  smo_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  smo_pkg::out_item_t out_item;

  // Shadow copy of the stack, updated on every accepted transaction.
  logic signed [smo_pkg::WORD_W-1:0] stack_words [STACK_DEPTH];
  int unsigned                       word_count = 0;

  smo_pkg::out_item_t pending_results[$];
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count    = 0;

  // Idling knobs, changed by the stimulus at phase boundaries.
  int unsigned send_idle_pct   = 0;
  int unsigned stall_pct       = 0;
  bit          hold_off_wanted = 1'b0;
  bit          hold_off_done   = 1'b0;

  stack_with_middle_ops #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow stack and return the answer it earns.
  // The middle is always index count/2, so it is not kept separately.
  function automatic smo_pkg::out_item_t apply_request(input smo_pkg::in_item_t req);
    smo_pkg::out_item_t res;
    int unsigned        k;
    res.read_value = '0;
    res.status     = smo_pkg::STAT_OK;
    if (req.command == smo_pkg::CMD_PUSH) begin
      if (word_count >= STACK_DEPTH) begin
        // Full: drop the word, leave the stack alone.
        res.status = smo_pkg::STAT_FULL;
      end else begin
        stack_words[word_count] = req.push_value;
        word_count++;
      end
    end else if (word_count == 0) begin
      res.read_value = smo_pkg::EMPTY_WORD;
      res.status     = smo_pkg::STAT_EMPTY;
    end else if (req.command == smo_pkg::CMD_POP) begin
      word_count--;
      res.read_value = stack_words[word_count];
    end else begin
      res.read_value = stack_words[word_count / 2];
      if (req.command == smo_pkg::CMD_DEL_MID) begin
        // Close the gap: shift everything above the middle down one place.
        for (k = word_count / 2; k + 1 < word_count; k++) begin
          stack_words[k] = stack_words[k + 1];
        end
        word_count--;
      end
    end
    return res;
  endfunction

  function automatic directed_row_t make_row(input logic [1:0] cmd,
                                             input logic [smo_pkg::WORD_W-1:0] value,
                                             input bit fixed,
                                             input logic [smo_pkg::WORD_W-1:0] read_value,
                                             input logic [1:0] status);
    directed_row_t r;
    r.req.command     = cmd;
    r.req.push_value  = value;
    r.fixed           = fixed;
    r.want.read_value = read_value;
    r.want.status     = status;
    return r;
  endfunction

  function automatic logic [smo_pkg::WORD_W-1:0] random_word();
    logic [smo_pkg::WORD_W-1:0] w;
    w = $urandom;
    // Lean on the extremes now and then.
    case ($urandom_range(15))
      0:       w = 32'h8000_0000;
      1:       w = 32'h7FFF_FFFF;
      2:       w = 32'hFFFF_FFFF;
      3:       w = 32'h0000_0000;
      default: ;
    endcase
    return w;
  endfunction

  // Offer one transaction at the falling edge, hold it until accepted, then
  // queue the answer: the hand-typed one if the row has it, else predicted.
  task automatic issue_request(input smo_pkg::in_item_t req, input bit fixed,
                               input smo_pkg::out_item_t want);
    smo_pkg::out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid           = 1'b0;
      in_item.push_value = $urandom;
      in_item.command    = 2'($urandom_range(3));
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = req;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(req);
    pending_results.push_back(fixed ? want : predicted);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Receiver: stall at random, and once hold off for a long stretch so the
  // block fills up and pushes back on its input.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_wanted && !hold_off_done) begin
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    smo_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result read_value=%0d status=%0d",
                 $time, out_item.read_value, out_item.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d got %0d",
                   $time, want.read_value, out_item.read_value);
          mismatch_count++;
        end
        if (out_item.status !== want.status) begin
          $display("%0t: status expected %0d got %0d",
                   $time, want.status, out_item.status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** stack_with_middle_ops: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t      plan[$];
    smo_pkg::in_item_t  req;
    smo_pkg::out_item_t none;
    depth_trend_t       trend;
    int unsigned        linger;
    int unsigned        push_pct;
    int unsigned        idx;

    none   = '0;
    trend  = GROW;
    linger = 0;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: empty-stack answers, a single word read and deleted
    // (delete of the last word empties the stack), extreme words, then
    // middle reads and deletes at odd and even depths down to empty.
    plan.push_back(make_row(smo_pkg::CMD_POP,      32'h1234_5678, 1,
                            smo_pkg::EMPTY_WORD, smo_pkg::STAT_EMPTY));
    plan.push_back(make_row(smo_pkg::CMD_READ_MID, 32'hFFFF_FFFF, 1,
                            smo_pkg::EMPTY_WORD, smo_pkg::STAT_EMPTY));
    plan.push_back(make_row(smo_pkg::CMD_DEL_MID,  32'h0000_0000, 1,
                            smo_pkg::EMPTY_WORD, smo_pkg::STAT_EMPTY));
    plan.push_back(make_row(smo_pkg::CMD_PUSH,     32'h8000_0000, 1,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_READ_MID, 32'h7FFF_FFFF, 0,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_DEL_MID,  32'hDEAD_BEEF, 0,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_POP,      32'h0000_0001, 1,
                            smo_pkg::EMPTY_WORD, smo_pkg::STAT_EMPTY));
    plan.push_back(make_row(smo_pkg::CMD_PUSH,     32'h7FFF_FFFF, 1,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_PUSH,     32'hFFFF_FFFF, 1,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_PUSH,     32'h0000_0000, 1,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_PUSH,     32'h0000_0001, 1,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_PUSH,     32'h5555_5555, 1,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_PUSH,     32'hAAAA_AAAA, 1,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_READ_MID, 32'h0F0F_0F0F, 0,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_DEL_MID,  32'hF0F0_F0F0, 0,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_READ_MID, 32'h8000_0000, 0,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_DEL_MID,  32'h0000_0000, 0,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_POP,      32'hFFFF_FFFF, 0,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_POP,      32'h7FFF_FFFF, 0,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_DEL_MID,  32'h1111_1111, 0,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_POP,      32'h2222_2222, 0,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_POP,      32'h3333_3333, 1,
                            smo_pkg::EMPTY_WORD, smo_pkg::STAT_EMPTY));
    plan.push_back(make_row(smo_pkg::CMD_PUSH,     32'hCAFE_F00D, 1,
                            32'd0, smo_pkg::STAT_OK));
    plan.push_back(make_row(smo_pkg::CMD_DEL_MID,  32'h4444_4444, 0,
                            32'd0, smo_pkg::STAT_OK));

    foreach (plan[i]) begin
      issue_request(plan[i].req, plan[i].fixed, plan[i].want);
    end

    // Random part: steer the depth between empty and full so that full
    // pushes, long middle deletes and empty answers all turn up, while
    // the idling phases rotate underneath.
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      case (idx / 250)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 66;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 66;
        end
        3: begin
          send_idle_pct = 38;
          stall_pct     = 38;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      // Back up the output while the sender keeps going.
      if (idx == 120) hold_off_wanted = 1'b1;

      case (trend)
        GROW: begin
          push_pct = 80;
          if (word_count == STACK_DEPTH) begin
            linger++;
            if (linger > 12) begin
              trend  = SHRINK;
              linger = 0;
            end
          end
        end
        SHRINK: begin
          push_pct = 20;
          if (word_count == 0) begin
            linger++;
            if (linger > 6) begin
              trend  = ($urandom_range(1) != 0) ? GROW : WANDER;
              linger = 0;
            end
          end
        end
        default: begin
          push_pct = 50;
          if ($urandom_range(99) == 0) trend = GROW;
        end
      endcase

      req.push_value = random_word();
      if ($urandom_range(99) < push_pct) begin
        req.command = smo_pkg::CMD_PUSH;
      end else begin
        case ($urandom_range(2))
          0:       req.command = smo_pkg::CMD_POP;
          1:       req.command = smo_pkg::CMD_READ_MID;
          default: req.command = smo_pkg::CMD_DEL_MID;
        endcase
      end
      issue_request(req, 1'b0, none);
    end

    // Drain: stop idling, wait for every answer, then wait out DRAIN_CYCLES,
    // longer than the longest request, for anything stray.
    send_idle_pct = 0;
    stall_pct     = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("** stack_with_middle_ops: PASSED **");
    end else begin
      $display("** stack_with_middle_ops: FAILED **");
    end
    $finish;
  end

endmodule
